// ===== rtl/stwe_pkg.sv =====
// shared types, constants and the decay table function for the square tone block
`default_nettype none
package stwe_pkg;

	localparam int unsigned PHASE_BITS_DEF = 16;
	localparam int unsigned DECAY_DEPTH_DEF = 64;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIV_Q_W = 16;

	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam longint unsigned LOG2_50_Q16 = 64'd369876;

	// q30 factors 2^-(2^-k) for k = 1..8
	localparam longint unsigned FRAC_FACTOR_Q30 [8] = '{
		64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
		64'd1050733751, 64'd1062175490, 64'd1067942999, 64'd1070838486
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL   = 3'd0,
		CFG_ATTACK  = 3'd1,
		CFG_DECAY   = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_SUSTAIN = 3'd4,
		CFG_AMP     = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SEG_RELEASE,
		SEG_ATTACK,
		SEG_DECAY,
		SEG_SUSTAIN
	} seg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ROM,
		ST_DEC_MUL,
		ST_AMP_MUL,
		ST_FINISH,
		ST_OUT
	} stwe_state_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic div_go;
		logic rom_rd;
		logic dec_mul;
		logic amp_mul;
		logic finish;
		logic load_out;
	} stwe_cmd_t;

	typedef struct packed {
		logic on_eff;
		seg_t seg_now;
		seg_t seg_reg;
		logic div_done;
		logic out_free;
		logic tone_on;
	} stwe_status_t;

	// decay table entry from the q16 exponent of 2^-(i*log2(50)/depth)
	function automatic logic [15:0] decay_rom_entry(input longint unsigned e_q16);
		longint unsigned v;
		longint unsigned n;
		logic [7:0] f;
		v = 64'd1 << 30;
		n = e_q16 >> 16;
		f = 8'(e_q16 >> 8);
		for (int k = 0; k < 8; k++) begin
			if (f[7-k]) begin
				v = (v * FRAC_FACTOR_Q30[k]) >> 30;
			end
		end
		if (n > 64'd40) begin
			n = 64'd40;
		end
		return 16'(((v >> n) + (64'd1 << 14)) >> 15);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/stwe_if.sv =====
// valid/ready channel interfaces for tone items and output samples
`default_nettype none
interface stwe_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic        [15:0] tone_step;
	logic signed [15:0] mix_sample;

	modport source (output valid, output kind, output tone_step, output mix_sample,
		input ready);
	modport sink (input valid, input kind, input tone_step, input mix_sample,
		output ready);
endinterface

interface stwe_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               tone_active;

	modport source (output valid, output sample_out, output tone_active, input ready);
	modport sink (input valid, input sample_out, input tone_active, output ready);
endinterface
`default_nettype wire

// ===== rtl/stwe_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit 16 bits
`default_nettype none
module stwe_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [2*stwe_pkg::DIV_Q_W-1:0] num,
	input  wire logic [stwe_pkg::DIV_Q_W-1:0]   den,
	output logic                               done,
	output logic [stwe_pkg::DIV_Q_W-1:0]        quot
);
	import stwe_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_Q_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_Q_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] lq_q;
	logic [DIV_Q_W-1:0] den_q;
	logic [DIV_Q_W:0]   cand;
	logic               ge;
	logic [DIV_Q_W:0]   diff;

	assign cand = {rem_q, lq_q[DIV_Q_W-1]};
	assign ge   = cand >= {1'b0, den_q};
	assign diff = cand - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper half of the dividend is below the divisor, so it seeds the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[2*DIV_Q_W-1:DIV_Q_W];
			lq_q  <= num[DIV_Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_Q_W-1:0] : cand[DIV_Q_W-1:0];
			lq_q  <= {lq_q[DIV_Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = lq_q;
endmodule
`default_nettype wire

// ===== rtl/stwe_ctrl.sv =====
// sequencer for start and tick transactions
`default_nettype none
module stwe_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_kind,
	input  wire stwe_pkg::stwe_status_t status,
	output logic                        in_ready,
	output stwe_pkg::stwe_cmd_t         cmd
);
	import stwe_pkg::*;

	stwe_state_t state_q;
	stwe_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_kind) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!status.on_eff) begin
					state_d = ST_OUT;
				end else if (status.seg_now == SEG_SUSTAIN) begin
					state_d = ST_AMP_MUL;
				end else begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = (status.seg_reg == SEG_DECAY) ? ST_ROM : ST_AMP_MUL;
				end
			end
			ST_ROM:     state_d = ST_DEC_MUL;
			ST_DEC_MUL: state_d = ST_AMP_MUL;
			ST_AMP_MUL: state_d = ST_FINISH;
			ST_FINISH:  state_d = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_CHECK:   cmd.check   = 1'b1;
			ST_DIV_GO:  cmd.div_go  = 1'b1;
			ST_ROM:     cmd.rom_rd  = 1'b1;
			ST_DEC_MUL: cmd.dec_mul = 1'b1;
			ST_AMP_MUL: cmd.amp_mul = 1'b1;
			ST_FINISH:  cmd.finish  = 1'b1;
			ST_OUT:     cmd.load_out = status.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/stwe_datapath.sv =====
// config registers, tone state, envelope arithmetic and output register
`default_nettype none
module stwe_datapath #(
	parameter int unsigned PHASE_BITS        = stwe_pkg::PHASE_BITS_DEF,
	parameter int unsigned DECAY_TABLE_DEPTH = stwe_pkg::DECAY_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stwe_pkg::stwe_cmd_t           cmd,
	input  wire logic                          cfg_wen,
	input  wire logic [stwe_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [stwe_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_kind,
	input  wire logic [15:0]                   in_tone_step,
	input  wire logic signed [15:0]            in_mix_sample,
	input  wire logic                          out_ready,
	output stwe_pkg::stwe_status_t             status,
	output logic                               out_valid,
	output logic signed [15:0]                 out_sample,
	output logic                               out_active
);
	import stwe_pkg::*;

	localparam int unsigned IDX_W = $clog2(DECAY_TABLE_DEPTH);

	logic [15:0] total_q, attack_q, decay_q, release_q, sustain_q;
	logic [14:0] amp_q;

	logic                  tone_on_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0]           inc_q;
	logic [15:0]           elapsed_q;

	logic signed [15:0] mix_q;
	seg_t               seg_q;
	logic [31:0]        num_q;
	logic [15:0]        env_q;
	logic [15:0]        rom_q;
	logic [31:0]        prod_q;
	logic signed [15:0] res_sample_q;
	logic               res_active_q;
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic               out_active_q;

	logic [15:0]           s_eff;
	logic [15:0]           remain;
	logic [15:0]           t_dec;
	logic                  on_eff;
	seg_t                  seg_c;
	logic [15:0]           mul_a, mul_b;
	logic [31:0]           mul_p;
	logic [15:0]           div_den;
	logic                  div_done;
	logic [DIV_Q_W-1:0]    quot;
	logic [IDX_W-1:0]      rom_idx;
	logic [PHASE_BITS-1:0] step_s;
	logic [16:0]           mag17;
	logic [14:0]           mag;
	logic signed [17:0]    tone18;
	logic signed [17:0]    sum18;
	logic signed [15:0]    sat;
	logic [15:0]           elapsed_nx;
	logic [15:0]           rom_tab [DECAY_TABLE_DEPTH];

	for (genvar g = 0; g < DECAY_TABLE_DEPTH; g++) begin : g_rom
		localparam longint unsigned ExpQ16 = (longint'(g) * LOG2_50_Q16) / DECAY_TABLE_DEPTH;
		assign rom_tab[g] = decay_rom_entry(ExpQ16);
	end

	if (PHASE_BITS >= 16) begin : g_step_up
		assign step_s = PHASE_BITS'(inc_q) << (PHASE_BITS - 16);
	end else begin : g_step_dn
		assign step_s = PHASE_BITS'(inc_q >> (16 - PHASE_BITS));
	end

	assign s_eff  = (sustain_q > ONE_Q15) ? ONE_Q15 : sustain_q;
	assign remain = total_q - elapsed_q;
	assign t_dec  = elapsed_q - attack_q;
	assign on_eff = tone_on_q && (elapsed_q < total_q);

	// zero-length segments never match, so the divisor is never zero
	always_comb begin
		if (remain < release_q) begin
			seg_c = SEG_RELEASE;
		end else if (elapsed_q < attack_q) begin
			seg_c = SEG_ATTACK;
		end else if (t_dec < decay_q) begin
			seg_c = SEG_DECAY;
		end else begin
			seg_c = SEG_SUSTAIN;
		end
	end

	// one shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.check && seg_c == SEG_RELEASE) begin
			mul_a = s_eff;
			mul_b = remain;
		end else if (cmd.check && seg_c == SEG_DECAY) begin
			mul_a = t_dec;
			mul_b = 16'(DECAY_TABLE_DEPTH);
		end else if (cmd.dec_mul) begin
			mul_a = ONE_Q15 - s_eff;
			mul_b = rom_q;
		end else if (cmd.amp_mul) begin
			mul_a = env_q;
			mul_b = {1'b0, amp_q};
		end
	end
	assign mul_p = 32'(mul_a) * 32'(mul_b);

	always_comb begin
		case (seg_q)
			SEG_RELEASE: div_den = release_q;
			SEG_ATTACK:  div_den = attack_q;
			SEG_DECAY:   div_den = decay_q;
			default:     div_den = 16'd1;
		endcase
	end

	stwe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (num_q),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	assign rom_idx = (quot >= 16'(DECAY_TABLE_DEPTH)) ? IDX_W'(DECAY_TABLE_DEPTH - 1)
		: quot[IDX_W-1:0];

	assign mag17  = prod_q[31:15];
	assign mag    = (mag17 > 17'd32767) ? 15'h7fff : mag17[14:0];
	assign tone18 = phase_q[PHASE_BITS-1] ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
	assign sum18  = 18'(mix_q) + tone18;
	always_comb begin
		if (sum18 > 18'sd32767) begin
			sat = 16'sh7fff;
		end else if (sum18 < -18'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = sum18[15:0];
		end
	end
	assign elapsed_nx = elapsed_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= 16'd3200;
			attack_q  <= 16'd80;
			decay_q   <= 16'd2400;
			release_q <= 16'd320;
			sustain_q <= 16'd6554;
			amp_q     <= 15'd16000;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_TOTAL:   total_q   <= cfg_wdata;
				CFG_ATTACK:  attack_q  <= cfg_wdata;
				CFG_DECAY:   decay_q   <= cfg_wdata;
				CFG_RELEASE: release_q <= cfg_wdata;
				CFG_SUSTAIN: sustain_q <= cfg_wdata;
				CFG_AMP:     amp_q     <= cfg_wdata[14:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_on_q <= 1'b0;
			phase_q   <= '0;
			inc_q     <= '0;
			elapsed_q <= '0;
		end else begin
			if (cmd.accept && !in_kind) begin
				tone_on_q <= 1'b1;
				phase_q   <= '0;
				inc_q     <= in_tone_step;
				elapsed_q <= '0;
			end else if (cmd.check && !on_eff) begin
				tone_on_q <= 1'b0;
			end else if (cmd.finish) begin
				phase_q   <= phase_q + step_s;
				elapsed_q <= elapsed_nx;
				tone_on_q <= elapsed_nx < total_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_kind) begin
			mix_q <= in_mix_sample;
		end
		if (cmd.check) begin
			seg_q <= seg_c;
			num_q <= (seg_c == SEG_ATTACK) ? {1'b0, elapsed_q, 15'd0} : mul_p;
			env_q <= s_eff;
			if (!on_eff) begin
				res_sample_q <= mix_q;
				res_active_q <= 1'b0;
			end
		end
		if (div_done && seg_q != SEG_DECAY) begin
			env_q <= quot;
		end
		if (cmd.rom_rd) begin
			rom_q <= rom_tab[rom_idx];
		end
		if (cmd.dec_mul) begin
			env_q <= 16'(17'(s_eff) + 17'(mul_p[31:15]));
		end
		if (cmd.amp_mul) begin
			prod_q <= mul_p;
		end
		if (cmd.finish) begin
			res_sample_q <= sat;
			res_active_q <= elapsed_nx < total_q;
		end
		if (cmd.load_out) begin
			out_sample_q <= res_sample_q;
			out_active_q <= res_active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.on_eff   = on_eff;
	assign status.seg_now  = seg_c;
	assign status.seg_reg  = seg_q;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.tone_on  = tone_on_q;

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_active = out_active_q;
endmodule
`default_nettype wire

// ===== rtl/square_tone_with_envelope_top.sv =====
// top level of the square tone generator with four-segment envelope
//
// channel   dir  payload                    transaction
// item      in   kind, tone_step, mix_sample valid & ready
// result    out  sample_out, tone_active     valid & ready
// cfg       in   cfg_idx, cfg_wdata          cfg_wen
//
// a start is taken in idle; a tick checks the tone, goes straight to the output
// when it is off, scales by the amplitude in sustain, and otherwise first runs
// the 16-step divider shared by the envelope segments and the single multiplier
// reset clears tone state and loads the default register values
// the output register frees the sequencer as soon as a result is taken;
// a stalled result holds the sequencer in its last step
`default_nettype none
module square_tone_with_envelope_top #(
	parameter int unsigned PHASE_BITS        = stwe_pkg::PHASE_BITS_DEF,
	parameter int unsigned DECAY_TABLE_DEPTH = stwe_pkg::DECAY_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	stwe_in_if.sink                            item,
	stwe_out_if.source                         result,
	input  wire logic                          cfg_wen,
	input  wire logic [stwe_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [stwe_pkg::CFG_W-1:0]     cfg_wdata
);
	import stwe_pkg::*;

	stwe_cmd_t    cmd;
	stwe_status_t status;
	logic         in_ready;

	stwe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_kind  (item.kind),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	stwe_datapath #(
		.PHASE_BITS        (PHASE_BITS),
		.DECAY_TABLE_DEPTH (DECAY_TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wen       (cfg_wen),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_kind       (item.kind),
		.in_tone_step  (item.tone_step),
		.in_mix_sample (item.mix_sample),
		.out_ready     (result.ready),
		.status        (status),
		.out_valid     (result.valid),
		.out_sample    (result.sample_out),
		.out_active    (result.tone_active)
	);

	assign item.ready = in_ready;

`ifndef SYNTHESIS
	// after a tick is taken, the input is not ready in the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind) |=> !item.ready)
		else $error("input taken while a tick is in progress");

	// a start never produces a result
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && !item.kind) |=> !cmd.load_out)
		else $error("result loaded right after a start");

	// a new result only appears through a load from the sequencer
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.load_out))
		else $error("result valid without a load");

	// an active flag on a fresh result is only set while the tone is running
	a_active_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (!result.tone_active || status.tone_on))
		else $error("tone_active set while tone is off");
`endif
endmodule
`default_nettype wire

// ===== tb/square_tone_with_envelope_top_tb.sv =====
// self-checking testbench for the square tone generator with four-segment envelope
`timescale 1ns / 100ps
`default_nettype none
module square_tone_with_envelope_top_tb;
	import stwe_pkg::*;

	localparam int PB = PHASE_BITS_DEF;
	localparam int DEPTH = DECAY_DEPTH_DEF;
	localparam int ITEM_TARGET = 1750;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int IDLE_PCT = 19;
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam longint unsigned EXP_LOG2_50_Q16 = 64'd369876;
	// 2^-(2^-k) in q30, k = 1..8
	localparam longint unsigned HALVING_Q30 [8] = '{
		64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
		64'd1050733751, 64'd1062175490, 64'd1067942999, 64'd1070838486
	};

	typedef enum bit {OP_ITEM, OP_WRITE} row_op_t;

	typedef struct {
		row_op_t            op;
		logic               kind;
		logic        [15:0] step;
		logic signed [15:0] mix;
		logic [CFG_IDX_W-1:0] idx;
		logic        [15:0] value;
		bit                 typed;
		logic signed [15:0] exp_sample;
		logic               exp_active;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] sample;
		logic               active;
	} tone_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;
	bit take_ready = 1'b0;
	bit steady = 1'b0;
	int cycles = 0;
	int mismatches = 0;
	int items_sent = 0;

	stwe_in_if item_ch();
	stwe_out_if sample_ch();

	assign sample_ch.ready = take_ready;

	square_tone_with_envelope_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (sample_ch),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// predictor copy of registers and tone state
	logic [15:0] reg_total, reg_attack, reg_decay, reg_release, reg_sustain;
	logic [14:0] reg_amp;
	logic tone_sounding;
	logic [PB-1:0] phase;
	logic [15:0] step_held;
	logic [15:0] sample_count;
	int unsigned decay_curve [DEPTH];

	tone_sample_t expected_samples [$];

	function automatic int unsigned envelope_q15(input logic [15:0] e);
		int unsigned s, remain, t, idx;
		s = (reg_sustain > 16'h8000) ? 32'd32768 : 32'(reg_sustain);
		remain = 32'(reg_total) - 32'(e);
		if (remain < 32'(reg_release)) begin
			return 32'((64'(s) * remain) / reg_release);
		end
		if (e < reg_attack) begin
			return 32'((64'(e) * 32768) / reg_attack);
		end
		t = 32'(e) - 32'(reg_attack);
		if (t < 32'(reg_decay)) begin
			idx = 32'((64'(t) * DEPTH) / reg_decay);
			if (idx >= DEPTH) begin
				idx = DEPTH - 1;
			end
			return s + 32'((64'(32768 - s) * decay_curve[idx]) >> 15);
		end
		return s;
	endfunction

	task automatic predict_sample(input logic kind, input logic [15:0] step,
		input logic signed [15:0] mix, output bit produces, output tone_sample_t r);
		int unsigned mag;
		int tone, sum;
		longint unsigned inc_scaled;
		produces = 1'b0;
		r = '{sample: '0, active: 1'b0};
		if (kind == KIND_START) begin
			tone_sounding = 1'b1;
			phase = '0;
			step_held = step;
			sample_count = '0;
			return;
		end
		produces = 1'b1;
		tone = 0;
		if (tone_sounding && sample_count >= reg_total) begin
			tone_sounding = 1'b0;
		end
		if (tone_sounding) begin
			mag = 32'((64'(envelope_q15(sample_count)) * reg_amp) >> 15);
			if (mag > 32767) begin
				mag = 32767;
			end
			tone = phase[PB-1] ? -int'(mag) : int'(mag);
			inc_scaled = (PB >= 16) ? (64'(step_held) << (PB >= 16 ? PB - 16 : 0))
				: (64'(step_held) >> (PB < 16 ? 16 - PB : 0));
			phase = phase + PB'(inc_scaled);
			sample_count = sample_count + 16'd1;
			if (sample_count >= reg_total) begin
				tone_sounding = 1'b0;
			end
		end
		sum = int'(mix) + tone;
		if (sum > 32767) begin
			sum = 32767;
		end
		if (sum < -32768) begin
			sum = -32768;
		end
		r.sample = 16'(sum);
		r.active = tone_sounding;
	endtask

	task automatic send_item(input logic kind, input logic [15:0] step,
		input logic signed [15:0] mix, input bit typed = 1'b0,
		input logic signed [15:0] typed_sample = '0, input logic typed_active = 1'b0);
		int gaps;
		bit produces;
		tone_sample_t r;
		gaps = 0;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			gaps++;
		end
		if (gaps > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.tone_step <= step;
		item_ch.mix_sample <= mix;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		predict_sample(kind, step, mix, produces, r);
		if (produces) begin
			if (typed) begin
				r.sample = typed_sample;
				r.active = typed_active;
			end
			expected_samples.push_back(r);
		end
	endtask

	// a start leaves no result behind, so pause past the longest tick as well
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_TOTAL:   reg_total = value;
			CFG_ATTACK:  reg_attack = value;
			CFG_DECAY:   reg_decay = value;
			CFG_RELEASE: reg_release = value;
			CFG_SUSTAIN: reg_sustain = value;
			CFG_AMP:     reg_amp = value[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_len();
		case ($urandom_range(19))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd1;
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [15:0] pick_step();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_mix();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		take_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** square_tone_with_envelope_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		tone_sample_t want;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample_out: no transaction expected, got %0d", sample_ch.sample_out);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_ch.sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d", want.sample,
						sample_ch.sample_out);
					mismatches++;
				end
				if (sample_ch.tone_active !== want.active) begin
					$error("tone_active: expected %0d, got %0d", want.active,
						sample_ch.tone_active);
					mismatches++;
				end
			end
		end
	end

	initial begin
		stim_row_t directed_rows [$];
		longint unsigned e_q16, n, v;
		logic [7:0] f;
		logic [15:0] total;
		logic [15:0] value;
		int ticks;

		item_ch.valid <= 1'b0;
		item_ch.kind <= KIND_TICK;
		item_ch.tone_step <= '0;
		item_ch.mix_sample <= '0;
		cfg_wen <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;

		// decay curve 0.02^(i/depth) as 2^-(i*log2(50)/depth)
		for (int i = 0; i < DEPTH; i++) begin
			e_q16 = (64'(i) * EXP_LOG2_50_Q16) / DEPTH;
			n = e_q16 >> 16;
			f = 8'(e_q16 >> 8);
			v = 64'd1 << 30;
			for (int k = 0; k < 8; k++) begin
				if (f[7-k]) begin
					v = (v * HALVING_Q30[k]) >> 30;
				end
			end
			if (n > 40) begin
				n = 40;
			end
			decay_curve[i] = 32'(((v >> n) + (64'd1 << 14)) >> 15);
		end
		reg_total = 16'd3200;
		reg_attack = 16'd80;
		reg_decay = 16'd2400;
		reg_release = 16'd320;
		reg_sustain = 16'd6554;
		reg_amp = 15'd16000;
		tone_sounding = 1'b0;
		phase = '0;
		step_held = '0;
		sample_count = '0;

		directed_rows = '{
			// tone off after reset: background passes through
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd0, '0, '0, 1'b1, 16'sd0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sh7FFF, '0, '0, 1'b1, 16'sh7FFF, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sh8000, '0, '0, 1'b1, 16'sh8000, 1'b0},
			// short tone through all four segments at full amplitude
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_TOTAL, 16'd6, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_ATTACK, 16'd2, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_DECAY, 16'd2, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_RELEASE, 16'd2, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_SUSTAIN, 16'd16384, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_AMP, 16'd32767, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_START, 16'h8000, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sh7FFF, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sh8000, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sh7FFF, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, -16'sd1, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd12345, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, -16'sd1234, '0, '0, 1'b0, '0, 1'b0},
			// zero-length segments, sustain clipped to one
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_ATTACK, 16'd0, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_DECAY, 16'd0, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_RELEASE, 16'd0, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_SUSTAIN, 16'hFFFF, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_TOTAL, 16'd3, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_START, 16'hFFFF, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, -16'sd20000, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd20000, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd7, '0, '0, 1'b1, 16'sd7, 1'b0},
			// restart while sounding, then length cut below the count
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_TOTAL, 16'd40, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_START, 16'h4000, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd100, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, -16'sd100, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_START, 16'h1234, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd300, '0, '0, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_TOTAL, 16'd1, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd555, '0, '0, 1'b1, 16'sd555, 1'b0},
			// unused register indexes are dropped
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_SPARE_LO, 16'hFFFF, 1'b0, '0, 1'b0},
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_SPARE_HI, 16'hFFFF, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, -16'sd555, '0, '0, 1'b1, -16'sd555, 1'b0},
			// zero length: the first tick finds the tone over
			'{OP_WRITE, KIND_TICK, '0, '0, CFG_TOTAL, 16'd0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_START, 16'h0001, 16'sd0, '0, '0, 1'b0, '0, 1'b0},
			'{OP_ITEM, KIND_TICK, 16'h0, 16'sd100, '0, '0, 1'b1, 16'sd100, 1'b0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == OP_WRITE) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				send_item(directed_rows[i].kind, directed_rows[i].step, directed_rows[i].mix,
					directed_rows[i].typed, directed_rows[i].exp_sample,
					directed_rows[i].exp_active);
			end
		end

		// random phases: new setting, then mostly one full tone
		while (items_sent < ITEM_TARGET) begin
			steady = (items_sent >= 700 && items_sent < 1000);
			settle();
			case ($urandom_range(9))
				0: total = 16'hFFFF;
				1: total = 16'd1;
				2: total = 16'd0;
				default: total = 16'($urandom_range(2, 120));
			endcase
			write_reg(CFG_TOTAL, total);
			write_reg(CFG_ATTACK, pick_len());
			write_reg(CFG_DECAY, pick_len());
			write_reg(CFG_RELEASE, pick_len());
			case ($urandom_range(5))
				0: value = 16'd0;
				1: value = 16'h8000;
				2: value = 16'($urandom_range(32769, 65535));
				default: value = 16'($urandom_range(0, 32768));
			endcase
			write_reg(CFG_SUSTAIN, value);
			case ($urandom_range(4))
				0: value = 16'd0;
				1: value = 16'd32767;
				2: value = 16'($urandom);
				default: value = 16'($urandom_range(0, 32767));
			endcase
			write_reg(CFG_AMP, value);
			if ($urandom_range(3) == 0) begin
				write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
			end
			if ($urandom_range(9) != 0) begin
				send_item(KIND_START, pick_step(), pick_mix());
			end
			if (total > 200) begin
				ticks = $urandom_range(50, 200);
			end else begin
				ticks = $urandom_range((total > 8) ? total - 8 : 0, total + 8);
			end
			repeat (ticks) begin
				if ($urandom_range(99) < 3) begin
					send_item(KIND_START, pick_step(), pick_mix());
				end else begin
					send_item(KIND_TICK, 16'($urandom), pick_mix());
				end
			end
		end
		steady = 1'b0;

		item_ch.valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("** square_tone_with_envelope_top: PASSED **");
		end else begin
			$display("** square_tone_with_envelope_top: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
